// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, reset on i_rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg
// types, codes and defaults shared by the membership table modules
// ----------------------------------------------------------------------------
package mta_pkg;

    localparam int TABLE_ENTRIES_DEF    = 32;
    localparam int GROUPS_PER_ENTRY_DEF = 8;
    localparam logic [7:0] AGE_LIMIT_RESET = 8'd50;

    // command codes
    localparam logic [2:0] CMD_JOIN    = 3'd0;
    localparam logic [2:0] CMD_LEAVE   = 3'd1;
    localparam logic [2:0] CMD_RSTART  = 3'd2;
    localparam logic [2:0] CMD_RADD    = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;
    localparam logic [2:0] CMD_TICK    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_LIST_FULL  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN    = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] robot;
        logic [15:0] swarm;
    } t_in_item;

    typedef struct packed {
        logic       is_member;
        logic [1:0] status;
    } t_out_item;

    // classified work item passed from front to back
    typedef struct packed {
        t_in_item item;
        logic     nop;
    } t_work;

endpackage

// File: src/mta_front.sv
// ----------------------------------------------------------------------------
// mta_front
// accepts items, flags unused commands and buffers them for the engine
// ----------------------------------------------------------------------------
module mta_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mta_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_work_valid,
    output mta_pkg::t_work    o_work,
    input  logic              i_work_pop
);
    import mta_pkg::*;

    localparam int QD = 2;

    t_work      r_q [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_work      w_cls;

    // classify: unused codes need no table work
    always_comb begin
        w_cls.item = i_item;
        w_cls.nop  = !(i_item.cmd inside {CMD_JOIN, CMD_LEAVE, CMD_RSTART,
                                          CMD_RADD, CMD_QUERY, CMD_TICK});
    end

    assign o_full       = (r_cnt == 2'(QD));
    assign o_work_valid = (r_cnt != 2'd0);
    assign o_work       = r_q[r_rp];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_work_pop && o_work_valid;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cls;
    end

endmodule

// File: src/mta_engine.sv
// ----------------------------------------------------------------------------
// mta_engine
// table lookup, list scan and compaction, ageing; one item at a time
// ----------------------------------------------------------------------------
module mta_engine #(
    parameter int TABLE_ENTRIES    = mta_pkg::TABLE_ENTRIES_DEF,
    parameter int GROUPS_PER_ENTRY = mta_pkg::GROUPS_PER_ENTRY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_age_limit,
    input  logic               i_work_valid,
    input  mta_pkg::t_work     i_work,
    output logic               o_work_pop,
    output logic               o_res_valid,
    output mta_pkg::t_out_item o_res,
    input  logic               i_res_ready
);
    import mta_pkg::*;

    localparam int TE = TABLE_ENTRIES;
    localparam int G  = GROUPS_PER_ENTRY;
    localparam int SW = $clog2(TE);
    localparam int CW = $clog2(G + 1);
    localparam int AW = $clog2(TE * G);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_SH_RD = 3'd5;
    localparam logic [2:0] S_SH_WR = 3'd6;
    localparam logic [2:0] S_RES   = 3'd7;

    // control state
    logic [2:0]    r_state, n_state;
    logic [TE-1:0] r_valid, n_valid;
    logic [SW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_k, n_k;
    logic          r_member, n_member;
    logic [1:0]    r_status, n_status;

    // payload
    logic [2:0]    r_cmd;
    logic [15:0]   r_rob, r_sw, r_rd;
    logic [TE-1:0] r_hit, r_free;
    logic [15:0]   r_robot [TE];
    logic [7:0]    r_age   [TE];
    logic [CW-1:0] r_cnt   [TE];
    logic [15:0]   mem     [TE*G];

    logic          w_hit_any, w_free_any;
    logic [SW-1:0] w_enc_hit, w_enc_free, w_sel, w_widx;
    logic [CW-1:0] w_cnt;
    logic          wr_robot, age_clr, cnt_we, tick_en, mem_we, mem_re;
    logic [CW-1:0] cnt_wd, mem_wk, mem_rk;
    logic [15:0]   mem_wd;
    logic [AW-1:0] mem_waddr, mem_raddr;

    // lowest set bit of the match and free vectors
    always_comb begin
        w_enc_hit  = '0;
        w_enc_free = '0;
        for (int i = TE - 1; i >= 0; i--) begin
            if (r_hit[i])  w_enc_hit  = SW'(i);
            if (r_free[i]) w_enc_free = SW'(i);
        end
    end

    assign w_hit_any  = |r_hit;
    assign w_free_any = |r_free;
    assign w_sel      = w_hit_any ? w_enc_hit : w_enc_free;
    assign w_widx     = (r_state == S_SEL) ? w_sel : r_slot;
    assign w_cnt      = r_cnt[w_widx];
    assign mem_waddr  = AW'(w_widx) * AW'(G) + AW'(mem_wk);
    assign mem_raddr  = AW'(r_slot) * AW'(G) + AW'(mem_rk);

    assign o_res.is_member = r_member;
    assign o_res.status    = r_status;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_slot     = r_slot;
        n_k        = r_k;
        n_member   = r_member;
        n_status   = r_status;
        o_work_pop = 1'b0;
        o_res_valid = 1'b0;
        wr_robot   = 1'b0;
        age_clr    = 1'b0;
        cnt_we     = 1'b0;
        cnt_wd     = '0;
        tick_en    = 1'b0;
        mem_we     = 1'b0;
        mem_wk     = '0;
        mem_wd     = r_sw;
        mem_re     = 1'b0;
        mem_rk     = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_work_valid) begin
                    o_work_pop = 1'b1;
                    n_member   = 1'b0;
                    n_status   = ST_OK;
                    n_state    = i_work.nop ? S_RES : S_MATCH;
                end
            end
            S_MATCH: n_state = S_SEL;
            S_SEL: begin
                n_slot  = w_sel;
                n_k     = '0;
                n_state = S_RES;
                case (r_cmd)
                    CMD_JOIN: begin
                        if (w_hit_any) begin
                            age_clr = 1'b1;
                            n_state = S_RD;
                        end else if (w_free_any) begin
                            n_valid[w_enc_free] = 1'b1;
                            wr_robot = 1'b1;
                            age_clr  = 1'b1;
                            cnt_we   = 1'b1;
                            cnt_wd   = CW'(1);
                            mem_we   = 1'b1;
                        end else begin
                            n_status = ST_TABLE_FULL;
                        end
                    end
                    CMD_LEAVE, CMD_QUERY: begin
                        if (w_hit_any) begin
                            age_clr = (r_cmd == CMD_LEAVE);
                            n_state = S_RD;
                        end
                    end
                    CMD_RSTART: begin
                        if (w_hit_any || w_free_any) begin
                            n_valid[w_sel] = 1'b1;
                            wr_robot = !w_hit_any;
                            age_clr  = 1'b1;
                            cnt_we   = 1'b1;
                            cnt_wd   = '0;
                        end else begin
                            n_status = ST_TABLE_FULL;
                        end
                    end
                    CMD_RADD: begin
                        if (!w_hit_any) begin
                            n_status = ST_UNKNOWN;
                        end else if (w_cnt >= CW'(G)) begin
                            n_status = ST_LIST_FULL;
                        end else begin
                            mem_we = 1'b1;
                            mem_wk = w_cnt;
                            cnt_we = 1'b1;
                            cnt_wd = w_cnt + CW'(1);
                        end
                    end
                    CMD_TICK: begin
                        tick_en = 1'b1;
                        for (int i = 0; i < TE; i++) begin
                            if (r_valid[i] && ({1'b0, r_age[i]} + 9'd1 > {1'b0, i_age_limit}))
                                n_valid[i] = 1'b0;
                        end
                    end
                    default: n_state = S_RES;
                endcase
            end
            // scan the list one element at a time
            S_RD: begin
                if (r_k >= w_cnt) begin
                    n_state = S_RES;
                    if (r_cmd == CMD_JOIN) begin
                        if (w_cnt >= CW'(G)) begin
                            n_status = ST_LIST_FULL;
                        end else begin
                            mem_we = 1'b1;
                            mem_wk = w_cnt;
                            cnt_we = 1'b1;
                            cnt_wd = w_cnt + CW'(1);
                        end
                    end else if (r_cmd == CMD_LEAVE && w_cnt == '0) begin
                        n_valid[r_slot] = 1'b0;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_rd == r_sw) begin
                    n_member = (r_cmd == CMD_QUERY);
                    n_state  = (r_cmd == CMD_LEAVE) ? S_SH_RD : S_RES;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_RD;
                end
            end
            // close the gap left by a removed group
            S_SH_RD: begin
                if (r_k + CW'(1) < w_cnt) begin
                    mem_re  = 1'b1;
                    mem_rk  = r_k + CW'(1);
                    n_state = S_SH_WR;
                end else begin
                    cnt_we  = 1'b1;
                    cnt_wd  = w_cnt - CW'(1);
                    if (w_cnt == CW'(1)) n_valid[r_slot] = 1'b0;
                    n_state = S_RES;
                end
            end
            S_SH_WR: begin
                mem_we  = 1'b1;
                mem_wk  = r_k;
                mem_wd  = r_rd;
                n_k     = r_k + CW'(1);
                n_state = S_SH_RD;
            end
            S_RES: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_slot   <= '0;
            r_k      <= '0;
            r_member <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_slot   <= n_slot;
            r_k      <= n_k;
            r_member <= n_member;
            r_status <= n_status;
        end
    end

    // item latch and parallel robot compare
    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_cmd <= i_work.item.cmd;
            r_rob <= i_work.item.robot;
            r_sw  <= i_work.item.swarm;
        end
        for (int i = 0; i < TE; i++) begin
            r_hit[i]  <= r_valid[i] && (r_robot[i] == r_rob);
            r_free[i] <= !r_valid[i];
        end
    end

    // per-entry fields
    always_ff @(posedge i_clk) begin
        if (wr_robot) r_robot[w_widx] <= r_rob;
        if (cnt_we)   r_cnt[w_widx]   <= cnt_wd;
        if (tick_en) begin
            for (int i = 0; i < TE; i++) r_age[i] <= r_age[i] + 8'd1;
        end else if (age_clr) begin
            r_age[w_widx] <= 8'd0;
        end
    end

    // group list memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wd;
        if (mem_re) r_rd <= mem[mem_raddr];
    end

endmodule

// File: src/member_table_with_aging.sv
// Sequence: accept in idle, robot compare, slot select, then result for most commands; joins,
// leaves and queries scan the list one element at a time, and a leave then compacts it.
// Flow: one item at a time in the table engine; a new item is taken only after the
// result of the last has been accepted by the result register.
// Reset: i_rst_n synchronous, active low; empties the table and queues, age_limit to 50.
// ----------------------------------------------------------------------------
// member_table_with_aging
// neighbour membership table with per-entry group lists and tick ageing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module member_table_with_aging #(
    parameter int TABLE_ENTRIES    = mta_pkg::TABLE_ENTRIES_DEF,
    parameter int GROUPS_PER_ENTRY = mta_pkg::GROUPS_PER_ENTRY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mta_pkg::t_in_item  i_item,
    output logic               o_full,
    output logic               o_empty,
    output mta_pkg::t_out_item o_item,
    input  logic               i_pop,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mta_pkg::*;

    // register index, word address bit of paddr
    localparam logic REG_AGE_LIMIT = 1'b0;

    logic       r_age_limit_v;
    logic [7:0] r_age_limit;
    logic       w_cfg_wr;
    logic       w_work_valid, w_work_pop;
    t_work      w_work;
    logic       w_res_valid, w_res_ready;
    t_out_item  w_res;
    logic       r_out_valid;
    t_out_item  r_out;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_AGE_LIMIT) ? {24'd0, r_age_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit   <= AGE_LIMIT_RESET;
            r_age_limit_v <= 1'b0;
        end else begin
            r_age_limit_v <= 1'b1;
            if (w_cfg_wr && paddr[2] == REG_AGE_LIMIT) r_age_limit <= pwdata[7:0];
        end
    end

    mta_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_item       (i_item),
        .o_full       (o_full),
        .o_work_valid (w_work_valid),
        .o_work       (w_work),
        .i_work_pop   (w_work_pop)
    );

    mta_engine #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .GROUPS_PER_ENTRY (GROUPS_PER_ENTRY)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_age_limit  (r_age_limit),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_pop   (w_work_pop),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    // result register
    assign w_res_ready = !r_out_valid || i_pop;
    assign o_empty     = !r_out_valid;
    assign o_item      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) r_out <= w_res;
    end

    // checks
    `AST_NEXT(a_res_lands, w_res_valid && w_res_ready, !o_empty, "result transfer lost")
    `AST_NEXT(a_cfg_write, w_cfg_wr && paddr[2] == REG_AGE_LIMIT,
              r_age_limit == $past(pwdata[7:0]), "age limit write lost")
    `AST_NEXT(a_push_held, i_push && !o_full, w_work_valid, "accepted item not queued")
    `AST_IMP(a_cfg_live, r_age_limit_v && !o_empty, pready, "config port stalled")

endmodule

// File: test/member_table_with_aging_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// member_table_with_aging_tb
// drives membership commands and register writes into the table, predicts
// every reply with a behavioural copy of the table and checks each transfer
// ----------------------------------------------------------------------------
module member_table_with_aging_tb;
    import mta_pkg::*;

    localparam int NSLOT  = 32;
    localparam int NGRP   = 8;
    localparam int N_RAND = 1800;

    // behavioural membership table and queue of predicted replies
    class member_scoreboard;
        logic [7:0]  age_limit;
        bit          valid [NSLOT];
        logic [15:0] robot_id [NSLOT];
        logic [7:0]  age [NSLOT];
        int          count [NSLOT];
        logic [15:0] groups [NSLOT][NGRP];
        t_out_item   pending [$];
        int          n_fail;
        int          n_checked;
        int          n_by_status [4];
        int          n_members;

        function void clear();
            age_limit = AGE_LIMIT_RESET;
            foreach (valid[i]) valid[i] = 0;
            pending.delete();
        endfunction

        function int find_robot(logic [15:0] r);
            for (int i = 0; i < NSLOT; i++)
                if (valid[i] && robot_id[i] == r) return i;
            return -1;
        endfunction

        function int alloc_slot(logic [15:0] r);
            for (int i = 0; i < NSLOT; i++)
                if (!valid[i]) begin
                    valid[i] = 1; robot_id[i] = r; age[i] = 0; count[i] = 0;
                    return i;
                end
            return -1;
        endfunction

        function int find_group(int s, logic [15:0] g);
            for (int k = 0; k < count[s]; k++)
                if (groups[s][k] == g) return k;
            return -1;
        endfunction

        function logic [1:0] append(int s, logic [15:0] g);
            if (count[s] >= NGRP) return ST_LIST_FULL;
            groups[s][count[s]] = g;
            count[s]++;
            return ST_OK;
        endfunction

        // note an accepted input transfer and queue its reply
        function void note_input(t_in_item it);
            t_out_item r;
            int s;
            int k;
            r = '0;
            r.status = ST_OK;
            case (it.cmd)
                CMD_JOIN: begin
                    s = find_robot(it.robot);
                    if (s < 0) s = alloc_slot(it.robot);
                    if (s < 0) r.status = ST_TABLE_FULL;
                    else begin
                        age[s] = 0;
                        if (find_group(s, it.swarm) < 0) r.status = append(s, it.swarm);
                    end
                end
                CMD_LEAVE: begin
                    s = find_robot(it.robot);
                    if (s >= 0) begin
                        age[s] = 0;
                        k = find_group(s, it.swarm);
                        if (k >= 0) begin
                            for (int i = k; i + 1 < count[s]; i++)
                                groups[s][i] = groups[s][i + 1];
                            count[s]--;
                        end
                        if (count[s] == 0) valid[s] = 0;
                    end
                end
                CMD_RSTART: begin
                    s = find_robot(it.robot);
                    if (s < 0) s = alloc_slot(it.robot);
                    if (s < 0) r.status = ST_TABLE_FULL;
                    else begin
                        age[s] = 0;
                        count[s] = 0;
                    end
                end
                CMD_RADD: begin
                    s = find_robot(it.robot);
                    if (s < 0) r.status = ST_UNKNOWN;
                    else r.status = append(s, it.swarm);
                end
                CMD_QUERY: begin
                    s = find_robot(it.robot);
                    if (s >= 0 && find_group(s, it.swarm) >= 0) r.is_member = 1;
                end
                CMD_TICK: begin
                    for (int i = 0; i < NSLOT; i++)
                        if (valid[i]) begin
                            if (int'(age[i]) + 1 > int'(age_limit)) valid[i] = 0;
                            else age[i] = age[i] + 8'd1;
                        end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // compare one reply transfer with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending.size() == 0) begin
                $error("reply with no prediction waiting: %0h", got);
                n_fail++;
                return;
            end
            exp_r = pending.pop_front();
            n_checked++;
            n_by_status[exp_r.status]++;
            if (exp_r.is_member) n_members++;
            if (got.is_member !== exp_r.is_member) begin
                $error("is_member expected %0b actual %0b", exp_r.is_member, got.is_member);
                n_fail++;
            end
            if (got.status !== exp_r.status) begin
                $error("status expected %0d actual %0d", exp_r.status, got.status);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_push = 0;
    t_in_item    i_item = '0;
    logic        o_full;
    logic        o_empty;
    t_out_item   o_item;
    logic        i_pop = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    member_scoreboard sb;
    bit  calm = 0;
    bit  hold_off = 0;
    logic [15:0] robot_pool [8];
    logic [15:0] group_pool [12];

    always #5 i_clk = ~i_clk;

    member_table_with_aging i_dut (.*);

    // reply side: random pop, checked at each transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) sb.check_result(o_item);
        i_pop <= !hold_off && (calm || $urandom_range(99) >= 28);
    end

    // one input transfer, with random idle cycles before it
    task automatic send(input t_in_item it);
        if (!calm)
            while ($urandom_range(99) < 28) begin
                i_push <= 0;
                @(posedge i_clk);
            end
        i_push <= 1;
        i_item <= it;
        do @(posedge i_clk); while (o_full);
        sb.note_input(it);
    endtask

    task automatic send3(input logic [2:0] c, input logic [15:0] r, input logic [15:0] g);
        t_in_item it;
        it.cmd = c; it.robot = r; it.swarm = g;
        send(it);
    endtask

    // wait until every reply is in, then let the engine settle
    task automatic drain();
        i_push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_age_limit(input logic [7:0] v);
        psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        sb.age_limit = v;
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        int p;
        p = $urandom_range(99);
        if (p < 10) begin
            it.cmd   = 3'($urandom);
            it.robot = 16'($urandom);
            it.swarm = 16'($urandom);
        end else begin
            it.robot = robot_pool[$urandom_range(7)];
            it.swarm = group_pool[$urandom_range(11)];
            if (p < 35) it.cmd = CMD_JOIN;
            else if (p < 50) it.cmd = CMD_LEAVE;
            else if (p < 57) it.cmd = CMD_RSTART;
            else if (p < 70) it.cmd = CMD_RADD;
            else if (p < 88) it.cmd = CMD_QUERY;
            else it.cmd = CMD_TICK;
        end
        return it;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 3 + n / 8);
            send(rand_item());
        end
        calm = 0;
    endtask

    initial begin
        sb = new();
        sb.clear();
        foreach (robot_pool[i]) robot_pool[i] = 16'($urandom);
        robot_pool[0] = 16'h0000;
        robot_pool[1] = 16'hffff;
        foreach (group_pool[i]) group_pool[i] = 16'($urandom);
        group_pool[0] = 16'h0000;
        group_pool[1] = 16'hffff;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: joins, duplicate, list full, leave with compaction
        send3(CMD_JOIN, 16'h0000, 16'h0000);
        send3(CMD_JOIN, 16'h0000, 16'h0000);
        for (int g = 1; g <= NGRP; g++) send3(CMD_JOIN, 16'h0000, 16'(g));
        send3(CMD_QUERY, 16'h0000, 16'd3);
        send3(CMD_LEAVE, 16'h0000, 16'd3);
        send3(CMD_QUERY, 16'h0000, 16'd3);
        send3(CMD_LEAVE, 16'h1234, 16'd1);
        send3(CMD_RADD, 16'hffff, 16'hffff);
        send3(CMD_QUERY, 16'hffff, 16'hffff);
        // refresh: start, adds, empty list freed by leave of absent group
        send3(CMD_RSTART, 16'hffff, 16'h5555);
        send3(CMD_RADD, 16'hffff, 16'hffff);
        send3(CMD_RADD, 16'hffff, 16'hffff);
        send3(CMD_RSTART, 16'hffff, 16'h0);
        send3(CMD_LEAVE, 16'hffff, 16'h7);
        send3(CMD_QUERY, 16'hffff, 16'hffff);
        send3(3'd6, 16'h1, 16'h1);
        send3(3'd7, 16'hffff, 16'hffff);
        // fill the table, then table full
        for (int r = 0; r < NSLOT; r++) send3(CMD_RSTART, 16'(100 + r), 16'h0);
        send3(CMD_JOIN, 16'h9999, 16'h1);
        send3(CMD_RSTART, 16'h9999, 16'h1);
        drain();

        // limit zero: every entry gone on the first tick
        write_age_limit(8'd0);
        send3(CMD_TICK, 16'h0, 16'h0);
        send3(CMD_QUERY, 16'h0000, 16'h0000);
        drain();
        // limit at its top: age climbs to 255 and is evicted on the next tick
        write_age_limit(8'd255);
        send3(CMD_JOIN, 16'h4242, 16'h1);
        for (int t = 0; t < 257; t++) send3(CMD_TICK, 16'h0, 16'h0);
        send3(CMD_QUERY, 16'h4242, 16'h1);
        drain();

        // long hold-off on the reply side so the block backs up
        write_age_limit(8'd3);
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(150);
        join
        drain();

        write_age_limit(8'd254);
        random_phase(500);
        drain();
        write_age_limit(8'd8);
        random_phase(600);
        drain();
        write_age_limit(AGE_LIMIT_RESET);
        random_phase(250);
        drain();

        $display("checked %0d replies: ok %0d, table full %0d, list full %0d, unknown %0d",
                 sb.n_checked, sb.n_by_status[0], sb.n_by_status[1],
                 sb.n_by_status[2], sb.n_by_status[3]);
        $display("%0d queries hit, age limits 0, 3, 8, 50, 254 and 255 used", sb.n_members);
        if (sb.n_fail == 0)
            $display("member_table_with_aging verification clean");
        else
            $display("member_table_with_aging verification failed");
        $finish;
    end

    // overall time limit
    initial begin
        #20ms;
        $display("member_table_with_aging verification failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/mta_pkg.sv
src/mta_front.sv
src/mta_engine.sv
src/member_table_with_aging.sv
test/member_table_with_aging_tb.sv
